[src/bcsc_pkg.sv]
// Shared types and constants for the block-CSC to CSR conversion unit
`default_nettype none
package bcsc_pkg;
   localparam int MaxValues    = 4096;
   localparam int MaxBlocks    = 1024;
   localparam int MaxBlockCols = 256;
   localparam int MaxRows      = 1024;
   localparam int MaxBlockEdge = 8;

   localparam int ValAw = $clog2(MaxValues);
   localparam int BlkAw = $clog2(MaxBlocks);
   localparam int ColAw = $clog2(MaxBlockCols + 1);
   localparam int RowAw = $clog2(MaxRows + 1);

   typedef enum logic [2:0] {
      CMD_WR_COLPTR = 3'd0,
      CMD_WR_BROW   = 3'd1,
      CMD_WR_VALUE  = 3'd2,
      CMD_CONVERT   = 3'd3,
      CMD_READ      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_BAD_ROW   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_EDGE  = 2'd0,
      REG_ROWS  = 2'd1,
      REG_BCOLS = 2'd2,
      REG_VALS  = 2'd3
   } reg_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_COL0, S_COL1, S_COL2, S_BLK0, S_BLK1,
      S_VAL0, S_VAL1, S_VAL2, S_VAL3, S_NEXT,
      S_PSUM0, S_PSUM1, S_PSUM2, S_FAIL, S_DONE, S_READ0, S_READ1, S_RESP,
      S_INIT
   } state_type;
endpackage
`default_nettype wire

[src/block_csc_to_csr_conversion_unit.sv]
// Top level: command decode, stores and conversion sequencer
// Loads and spare commands pass through S_DONE to the response, reads through S_READ0 and S_READ1;
// the input reopens the cycle after the response transfer, so one command is in flight at a time.
// Convert: clears the row pointers, then walks the columns twice (count, then scatter), reading
// each column's pointers, each block's row and each value, with a prefix step per row up to row
// count between walks; a failed walk clears the row pointers again. Each memory has one port.
// Reset (synchronous, active high) sets defaults, then a pass zeroes the row pointers.
`default_nettype none
module block_csc_to_csr_conversion_unit
   import bcsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_command,
   input  wire logic [11:0] req_slot,
   input  wire logic [10:0] req_pointer_word,
   input  wire logic [63:0] req_value_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [12:0]      rsp_nonzero_total,
   output logic [63:0]      rsp_result_value,
   output logic [10:0]      rsp_result_column,
   output logic [12:0]      rsp_result_row_start,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   // memories
   logic [10:0] colptr_mem [MaxBlockCols+1];
   logic [9:0]  brow_mem   [MaxBlocks];
   logic [63:0] bval_mem   [MaxValues];
   logic [63:0] oval_mem   [MaxValues];
   logic [10:0] ocol_mem   [MaxValues];
   logic [12:0] rptr_mem   [MaxRows+1];
   logic [12:0] fcur_mem   [MaxRows];

   logic [3:0]  edge_ff;
   logic [10:0] rows_ff;
   logic [8:0]  bcols_ff;
   logic [12:0] vals_ff;

   state_type state_ff, state_in;
   logic [11:0] slot_ff;
   logic [1:0]  status_ff;
   logic [12:0] nnz_ff;

   // walk context
   logic        pass_ff;        // 0 count, 1 scatter
   logic [8:0]  j_ff;
   logic [10:0] i_ff, iend_ff;
   logic [9:0]  brow_ff;
   logic [3:0]  r_ff, c_ff;
   logic [12:0] used_ff;
   logic [10:0] k_ff;
   logic [12:0] acc_ff;
   logic [1:0]  err_ff;
   logic [63:0] v_ff;
   logic [13:0] row_ff;
   logic [12:0] pos_ff;

   // saturated registers
   logic [3:0]  edge_s;
   logic [10:0] rows_s;
   logic [8:0]  bcols_s;
   logic [12:0] vals_s;
   assign edge_s  = (edge_ff > 4'(MaxBlockEdge)) ? 4'(MaxBlockEdge) : edge_ff;
   assign rows_s  = (rows_ff > 11'(MaxRows)) ? 11'(MaxRows) : rows_ff;
   assign bcols_s = (bcols_ff > 9'(MaxBlockCols)) ? 9'(MaxBlockCols) : bcols_ff;
   assign vals_s  = (vals_ff > 13'(MaxValues)) ? 13'(MaxValues) : vals_ff;

   // configuration port
   logic cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff  <= 4'd1;
         rows_ff  <= '0;
         bcols_ff <= '0;
         vals_ff  <= '0;
      end else if (cfg_wr) begin
         unique case (reg_type'(paddr[3:2]))
            REG_EDGE:  edge_ff  <= pwdata[3:0];
            REG_ROWS:  rows_ff  <= pwdata[10:0];
            REG_BCOLS: bcols_ff <= pwdata[8:0];
            REG_VALS:  vals_ff  <= pwdata[12:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (reg_type'(paddr[3:2]))
         REG_EDGE:  prdata = {28'd0, edge_ff};
         REG_ROWS:  prdata = {21'd0, rows_ff};
         REG_BCOLS: prdata = {23'd0, bcols_ff};
         REG_VALS:  prdata = {19'd0, vals_ff};
         default:   prdata = '0;
      endcase
   end

   // memory read data
   logic [10:0] cp_q;
   logic [9:0]  br_q;
   logic [63:0] bv_q, ov_q;
   logic [10:0] oc_q;
   logic [12:0] rp_q, fc_q;

   // address/enable selection
   logic [ColAw-1:0] cp_a;
   logic [BlkAw-1:0] br_a;
   logic [ValAw-1:0] bv_a, ov_a;
   logic [RowAw-1:0] rp_a;
   logic [RowAw-2:0] fc_a;
   logic cp_we, br_we, bv_we, o_we, rp_we, fc_we;
   logic [12:0] rp_d, fc_d;

   logic [13:0] rowcalc;
   assign rowcalc = 14'(brow_ff) * 14'(edge_s) + 14'(r_ff);
   // column counter runs one ahead while the blocks of a column are walked
   logic [10:0] colcalc;
   assign colcalc = 11'((12'(j_ff) - 12'd1) * 12'(edge_s) + 12'(c_ff));

   logic accept_in;
   assign req_ready = (state_ff == S_IDLE);
   assign accept_in = req_valid && req_ready;

   always_comb begin
      cp_a = ColAw'(slot_ff); br_a = BlkAw'(slot_ff); bv_a = ValAw'(slot_ff);
      ov_a = ValAw'(slot_ff); rp_a = RowAw'(slot_ff); fc_a = '0;
      cp_we = 1'b0; br_we = 1'b0; bv_we = 1'b0; o_we = 1'b0; rp_we = 1'b0; fc_we = 1'b0;
      rp_d = '0; fc_d = '0;
      unique case (state_ff)
         S_INIT: begin
            rp_a = k_ff; rp_we = 1'b1;
         end
         S_CLEAR: begin
            rp_a = k_ff; rp_we = 1'b1;
         end
         S_COL0: cp_a = ColAw'(j_ff);
         S_COL1: cp_a = ColAw'(j_ff + 9'd1);
         S_BLK0: br_a = BlkAw'(i_ff);
         S_VAL0: bv_a = ValAw'(used_ff);
         S_VAL2: begin
            rp_a = RowAw'(row_ff + 14'd1);
            fc_a = (RowAw-1)'(row_ff);
         end
         S_VAL3: begin
            rp_a = RowAw'(row_ff + 14'd1);
            fc_a = (RowAw-1)'(row_ff);
            if (!pass_ff) begin
               rp_we = 1'b1; rp_d = rp_q + 13'd1;
            end else begin
               fc_we = 1'b1; fc_d = fc_q + 13'd1;
               ov_a = ValAw'(fc_q);
               o_we = (fc_q < 13'(MaxValues));
            end
         end
         S_PSUM0: rp_a = k_ff;
         S_PSUM1: begin
            rp_a = k_ff; rp_we = 1'b1; rp_d = rp_q + acc_ff;
         end
         S_PSUM2: begin
            fc_a = (RowAw-1)'(k_ff); fc_we = (k_ff < rows_s); fc_d = acc_ff;
         end
         S_FAIL: begin
            rp_a = k_ff; rp_we = 1'b1;
         end
         default: ;
      endcase
      if (state_ff == S_IDLE) begin
         cp_a = ColAw'(req_slot); br_a = BlkAw'(req_slot); bv_a = ValAw'(req_slot);
         ov_a = ValAw'(req_slot); rp_a = RowAw'(req_slot);
         cp_we = accept_in && req_command == CMD_WR_COLPTR && req_slot < 12'(MaxBlockCols+1);
         br_we = accept_in && req_command == CMD_WR_BROW && req_slot < 12'(MaxBlocks);
         bv_we = accept_in && req_command == CMD_WR_VALUE;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (cp_we) colptr_mem[cp_a] <= req_pointer_word;
      cp_q <= colptr_mem[cp_a];
   end
   always_ff @(posedge clock) begin
      if (br_we) brow_mem[br_a] <= req_pointer_word[9:0];
      br_q <= brow_mem[br_a];
   end
   always_ff @(posedge clock) begin
      if (bv_we) bval_mem[bv_a] <= req_value_bits;
      bv_q <= bval_mem[bv_a];
   end
   always_ff @(posedge clock) begin
      if (o_we) begin
         oval_mem[ov_a] <= v_ff;
         ocol_mem[ov_a] <= colcalc;
      end
      ov_q <= oval_mem[ov_a];
      oc_q <= ocol_mem[ov_a];
   end
   always_ff @(posedge clock) begin
      if (rp_we) rptr_mem[rp_a] <= rp_d;
      rp_q <= rptr_mem[rp_a];
   end
   always_ff @(posedge clock) begin
      if (fc_we) fcur_mem[fc_a] <= fc_d;
      fc_q <= fcur_mem[fc_a];
   end

   // next state
   logic last_c, last_r;
   assign last_c = (c_ff + 4'd1 >= edge_s);
   assign last_r = (r_ff + 4'd1 >= edge_s);
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: if (k_ff == RowAw'(MaxRows)) state_in = S_IDLE;
         S_IDLE: if (accept_in) begin
            if (req_command == CMD_CONVERT) state_in = S_CLEAR;
            else if (req_command == CMD_READ) state_in = S_READ0;
            else state_in = S_DONE;
         end
         S_CLEAR: if (k_ff == RowAw'(MaxRows)) state_in = S_COL0;
         S_COL0: state_in = (j_ff >= bcols_s) ? (pass_ff ? S_DONE : S_PSUM0) : S_COL1;
         S_COL1: state_in = S_COL2;
         S_COL2: state_in = S_BLK0;
         S_BLK0: state_in = (i_ff >= iend_ff) ? S_COL0 : S_BLK1;
         S_BLK1: state_in = (edge_s == 4'd0) ? S_NEXT : S_VAL0;
         S_VAL0: state_in = (used_ff >= vals_s) ? S_FAIL : S_VAL1;
         S_VAL1: state_in = (bv_q[62:0] == 63'd0) ? S_NEXT
                          : (rowcalc >= 14'(rows_s)) ? S_FAIL : S_VAL2;
         S_VAL2: state_in = S_VAL3;
         S_VAL3: state_in = S_NEXT;
         S_NEXT: state_in = (last_c && last_r) || edge_s == 4'd0 ? S_BLK0 : S_VAL0;
         S_PSUM0: state_in = S_PSUM1;
         S_PSUM1: state_in = S_PSUM2;
         S_PSUM2: state_in = (k_ff >= rows_s) ? S_COL0 : S_PSUM0;
         S_FAIL: if (k_ff == RowAw'(MaxRows)) state_in = S_DONE;
         S_DONE: state_in = S_RESP;
         S_READ0: state_in = S_READ1;
         S_READ1: state_in = S_RESP;
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         status_ff <= ST_OK;
         nnz_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_FAIL && k_ff == RowAw'(MaxRows)) begin
            status_ff <= err_ff; nnz_ff <= '0;
         end else if (state_ff == S_COL0 && j_ff >= bcols_s && pass_ff) begin
            status_ff <= ST_OK; nnz_ff <= acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         unique case (state_ff)
            S_INIT: k_ff <= k_ff + 11'd1;
            S_IDLE: begin
               slot_ff <= req_slot;
               k_ff <= '0; pass_ff <= 1'b0; j_ff <= '0; used_ff <= '0; acc_ff <= '0;
            end
            S_CLEAR: k_ff <= (k_ff == RowAw'(MaxRows)) ? 11'd0 : k_ff + 11'd1;
            S_COL0: ;
            S_COL1: i_ff <= cp_q;
            S_COL2: begin
               iend_ff <= cp_q; j_ff <= j_ff + 9'd1;
            end
            S_BLK0: ;
            S_BLK1: begin
               brow_ff <= (i_ff < 11'(MaxBlocks)) ? br_q : 10'd0;
               r_ff <= '0; c_ff <= '0;
               j_ff <= j_ff;
            end
            S_VAL0: begin
               err_ff <= ST_EXHAUSTED; k_ff <= '0;
               used_ff <= used_ff + 13'd1;
            end
            S_VAL1: begin
               v_ff <= bv_q; row_ff <= rowcalc; err_ff <= ST_BAD_ROW; k_ff <= '0;
            end
            S_VAL2: ;
            S_VAL3: ;
            S_NEXT: begin
               if (last_c) begin
                  c_ff <= '0; r_ff <= r_ff + 4'd1;
                  if (last_r) i_ff <= i_ff + 11'd1;
               end else c_ff <= c_ff + 4'd1;
            end
            S_PSUM0: ;
            S_PSUM1: acc_ff <= rp_q + acc_ff;
            S_PSUM2: begin
               k_ff <= k_ff + 11'd1;
               if (k_ff >= rows_s) begin
                  pass_ff <= 1'b1; j_ff <= '0; used_ff <= '0;
               end
            end
            S_FAIL: k_ff <= k_ff + 11'd1;
            default: ;
         endcase
      end
   end

   // PSUM: acc holds sum of the entries below k; rp[k] becomes rp[k]+acc (entry 0 holds no count)
   // then acc grows by rp[k] for the next row. fill cursor k takes row_ptr[k] = acc_new.

   // response register
   logic [63:0] rv_ff;
   logic [10:0] rc_ff;
   logic [12:0] rs_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_READ1) begin
         rv_ff <= (13'(slot_ff) < nnz_ff) ? ov_q : '0;
         rc_ff <= (13'(slot_ff) < nnz_ff) ? oc_q : '0;
         rs_ff <= (11'(slot_ff) <= rows_s && slot_ff <= 12'(MaxRows)) ? rp_q : '0;
      end else if (state_ff == S_DONE) begin
         rv_ff <= '0; rc_ff <= '0; rs_ff <= '0;
      end
   end
   assign rsp_valid            = (state_ff == S_RESP);
   assign rsp_status           = status_ff;
   assign rsp_nonzero_total    = nnz_ff;
   assign rsp_result_value     = rv_ff;
   assign rsp_result_column    = rc_ff;
   assign rsp_result_row_start = rs_ff;
endmodule
`default_nettype wire

[src/bcsc_checker.sv]
// Port-level checker for the conversion unit, bound to the top level
`default_nettype none
module bcsc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [12:0] rsp_nonzero_total,
   input wire logic        pready
);
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input open while response pending");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status code");
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != 2'd0) |-> rsp_nonzero_total == 13'd0)
      else $error("failed convert left nonzeros");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
   a_pready: assert property (@(posedge clock) pready) else $error("pready low");
endmodule
bind block_csc_to_csr_conversion_unit bcsc_checker u_bcsc_checker (.*);
`default_nettype wire
